@@ design/hpc_pkg.sv @@
// Shared types, constants and helpers of the palette and hold-and-modify colorizer.
package hpc_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 24;
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 2;

	localparam logic [23:0] DEBUG_RGB = 24'hD00000;
	localparam logic [23:0] HALF_MASK = 24'h7F7F7F;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_HAM6   = 2'd1,
		MODE_HAM8   = 2'd2,
		MODE_UNUSED = 2'd3
	} pix_mode_t;

	typedef enum logic [1:0] {
		CFG_PIXEL_MODE = 2'd0,
		CFG_HALFBRIGHT = 2'd1,
		CFG_AGA_WRITES = 2'd2,
		CFG_BORDER_SPR = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BORDER_CLEAR      = 2'd0,
		BORDER_BACKGROUND = 2'd1,
		BORDER_BLANK      = 2'd2,
		BORDER_RED        = 2'd3
	} border_t;

	typedef enum logic [1:0] {
		HAM_LOAD  = 2'd0,
		HAM_BLUE  = 2'd1,
		HAM_RED   = 2'd2,
		HAM_GREEN = 2'd3
	} ham_ctrl_t;

	typedef enum logic [2:0] {
		SEL_BACKGROUND,
		SEL_BLANK,
		SEL_DEBUG,
		SEL_PALETTE,
		SEL_HAM
	} sel_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic        is_write;
		logic [7:0]  wr_addr;
		logic        we_hi;
		logic [11:0] hi_data;
		logic [11:0] lo_data;
		logic        line_start;
		logic        bkg_load;
		logic        ham_update;
		sel_t        sel;
		ham_ctrl_t   ctrl;
		logic [5:0]  mod_hi;
		logic        keep_low;
		logic [7:0]  mix_addr;
		logic        mix_oob;
		logic        mix_half;
		logic [7:0]  ham_addr;
		logic        ham_oob;
	} item_t;

	// Interleave high and low nibble sets into 8-bit components.
	function automatic logic [23:0] mk_color(input logic [11:0] hi, input logic [11:0] lo);
		return {hi[11:8], lo[11:8], hi[7:4], lo[7:4], hi[3:0], lo[3:0]};
	endfunction

	function automatic logic [11:0] hi_nibs(input logic [23:0] c);
		return {c[23:20], c[15:12], c[7:4]};
	endfunction

	function automatic logic [23:0] halve(input logic [23:0] c);
		return (c >> 1) & HALF_MASK;
	endfunction

endpackage

@@ design/ham_palette_colorizer.sv @@
// Top level of the palette and hold-and-modify colorizer.
//
// Input stream (s_axis): one item per transfer, in display order. tuser selects the
// kind: 0 a pixel, 1 a colour register write. A pixel gives exactly one RGB transfer
// on m_axis; a write gives none and updates the palette for all later pixels.
// Configuration (cfg_we, cfg_addr, cfg_wdata) is written while the stream is idle.
//
// Throughput: one item per clock when m_axis keeps tready high. An accepted pixel
// passes through the input queue, the registered palette read and the output
// register before its result appears at m_axis.
// The hold register is the only state fed back between pixels; it updates in the
// same cycle as the colour selection, so consecutive pixels do not wait on it.
//
// When m_axis stalls, the output register and stage 1 hold, then the queue fills
// and s_axis_tready drops; colour writes at the queue head keep draining meanwhile.
// Reset clears the palette (by per-entry valid bits), the hold register and all
// configuration, and needs no clearing pass.
module ham_palette_colorizer import hpc_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// line_start, border_code[1:0], sprite_present, sprite_visible, plane_data[7:0],
	// plane_index[7:0], mix_index[7:0], reg_number[7:0], reg_value[11:0], low_nibbles
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// red[7:0], green[7:0], blue[7:0]
	output logic [M_TDATA_W-1:0]  m_axis_tdata
);

	logic  q_full;
	logic  q_not_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	hpc_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	hpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.head      (head)
	);

	hpc_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ design/hpc_front.sv @@
// Front end: configuration registers, input acceptance and item classification.
module hpc_front import hpc_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [S_TDATA_W-1:0]  in_data,
	input  logic                  in_kind,
	input  logic                  q_full,
	output logic                  push,
	output item_t                 push_item
);

	localparam logic [8:0] PE_LIM = 9'(PALETTE_ENTRIES);

	pix_mode_t mode_q;
	logic      half_q;
	logic      aga_q;
	logic      bsp_q;

	logic        line_start;
	logic [1:0]  border_raw;
	logic        spr_present;
	logic        spr_visible;
	logic [7:0]  plane_data;
	logic [7:0]  plane_index;
	logic [7:0]  mix_index;
	logic [7:0]  reg_number;
	logic [11:0] reg_value;
	logic        low_nibbles;

	border_t    border_eff;
	logic       is_ham;
	logic       ham8;
	logic       mix_hb;
	logic [7:0] mix_eff;
	logic [7:0] ham_addr;
	logic       wr_oob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			half_q <= 1'b0;
			aga_q  <= 1'b0;
			bsp_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				CFG_PIXEL_MODE: mode_q <= pix_mode_t'(cfg_wdata[1:0]);
				CFG_HALFBRIGHT: half_q <= cfg_wdata[0];
				CFG_AGA_WRITES: aga_q  <= cfg_wdata[0];
				CFG_BORDER_SPR: bsp_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign line_start  = in_data[0];
	assign border_raw  = in_data[2:1];
	assign spr_present = in_data[3];
	assign spr_visible = in_data[4];
	assign plane_data  = in_data[12:5];
	assign plane_index = in_data[20:13];
	assign mix_index   = in_data[28:21];
	assign reg_number  = in_data[36:29];
	assign reg_value   = in_data[48:37];
	assign low_nibbles = in_data[49];

	assign border_eff = (bsp_q && spr_present) ? BORDER_CLEAR : border_t'(border_raw);
	assign is_ham     = (mode_q == MODE_HAM6) || (mode_q == MODE_HAM8);
	assign ham8       = (mode_q == MODE_HAM8);
	// Halfbright entries fold onto the lower 32 and are halved later
	assign mix_hb     = half_q && (mix_index[7:5] == 3'b001);
	assign mix_eff    = mix_hb ? {mix_index[7:6], 1'b0, mix_index[4:0]} : mix_index;
	assign ham_addr   = ham8 ? {2'b00, plane_index[7:2]} : plane_index;
	assign wr_oob     = {1'b0, reg_number} >= PE_LIM;

	always_comb begin
		push_item            = '0;
		push_item.is_write   = in_kind;
		push_item.wr_addr    = reg_number;
		push_item.we_hi      = !(aga_q && low_nibbles);
		push_item.hi_data    = reg_value;
		push_item.lo_data    = aga_q ? reg_value : 12'd0;
		push_item.line_start = line_start;
		push_item.bkg_load   = is_ham && (border_eff == BORDER_BACKGROUND);
		push_item.ham_update = is_ham && (border_eff == BORDER_CLEAR);
		push_item.ctrl       = ham_ctrl_t'(ham8 ? plane_data[1:0] : plane_data[5:4]);
		push_item.mod_hi     = ham8 ? plane_index[7:2] : {plane_index[3:0], 2'b00};
		push_item.keep_low   = ham8;
		push_item.mix_addr   = mix_eff;
		push_item.mix_oob    = {1'b0, mix_eff} >= PE_LIM;
		push_item.mix_half   = mix_hb;
		push_item.ham_addr   = ham_addr;
		push_item.ham_oob    = {1'b0, ham_addr} >= PE_LIM;
		case (border_eff)
			BORDER_BACKGROUND: push_item.sel = SEL_BACKGROUND;
			BORDER_BLANK:      push_item.sel = SEL_BLANK;
			BORDER_RED:        push_item.sel = SEL_DEBUG;
			default:           push_item.sel = (is_ham && !spr_visible) ? SEL_HAM : SEL_PALETTE;
		endcase
	end

	assign in_ready = !q_full;
	// Drop writes to registers beyond the palette
	assign push     = in_valid && in_ready && !(in_kind && wr_oob);

endmodule

@@ design/hpc_queue.sv @@
// Short item queue between the front and back ends.
module hpc_queue import hpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  not_empty,
	input  logic  pop,
	output item_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	item_t         ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = ent_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

@@ design/hpc_back.sv @@
// Back end: palette memories, hold register, pixel colour selection and output register.
module hpc_back import hpc_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  item_t                head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [M_TDATA_W-1:0] out_data
);

	localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// High and low nibble sets live apart so a low-nibble write needs no read
	logic [11:0] hi_mem [PALETTE_ENTRIES];
	logic [11:0] lo_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] vld_q;
	logic [23:0] c0_q;
	logic [23:0] hold_q;

	logic        s1_valid_q;
	item_t       item_s1;
	logic [23:0] c0_s1;
	logic [11:0] mix_hi_s1;
	logic [11:0] mix_lo_s1;
	logic        mix_v_s1;
	logic [11:0] ham_hi_s1;
	logic [11:0] ham_lo_s1;
	logic        ham_v_s1;

	logic        out_valid_q;
	logic [23:0] out_rgb_q;

	logic          s1_adv;
	logic          s1_free;
	logic          wr;
	logic          rd;
	logic [AW-1:0] waddr;
	logic [AW-1:0] maddr;
	logic [AW-1:0] haddr;
	logic [23:0]   mix_col;
	logic [23:0]   pal_col;
	logic [23:0]   ham_col;
	logic [23:0]   hold_base;
	logic [23:0]   hold_next;
	logic [7:0]    mod_val;
	logic [23:0]   rgb;

	assign s1_adv  = s1_valid_q && (!out_valid_q || out_ready);
	assign s1_free = !s1_valid_q || s1_adv;
	assign pop     = q_valid && (head.is_write || s1_free);
	assign wr      = pop && head.is_write;
	assign rd      = pop && !head.is_write;
	assign waddr   = head.wr_addr[AW-1:0];
	assign maddr   = head.mix_addr[AW-1:0];
	assign haddr   = head.ham_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr) begin
			// A first write of the low nibbles alone clears the stale high set
			if (head.we_hi || !vld_q[waddr]) begin
				hi_mem[waddr] <= head.we_hi ? head.hi_data : 12'd0;
			end
			lo_mem[waddr] <= head.lo_data;
		end
		if (rd) begin
			mix_hi_s1 <= hi_mem[maddr];
			mix_lo_s1 <= lo_mem[maddr];
			ham_hi_s1 <= hi_mem[haddr];
			ham_lo_s1 <= lo_mem[haddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			item_s1  <= head;
			c0_s1    <= c0_q;
			mix_v_s1 <= vld_q[maddr];
			ham_v_s1 <= vld_q[haddr];
		end
		if (s1_adv) begin
			out_rgb_q <= rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			c0_q        <= '0;
			hold_q      <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr) begin
				vld_q[waddr] <= 1'b1;
				// Shadow copy of colour 0 for border and line-start loads
				if (head.wr_addr == 8'd0) begin
					c0_q <= mk_color(head.we_hi ? head.hi_data : hi_nibs(c0_q), head.lo_data);
				end
			end
			if (rd) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				hold_q      <= hold_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		mix_col = (item_s1.mix_oob || !mix_v_s1) ? 24'd0 : mk_color(mix_hi_s1, mix_lo_s1);
		pal_col = item_s1.mix_half ? halve(mix_col) : mix_col;
		ham_col = (item_s1.ham_oob || !ham_v_s1) ? 24'd0 : mk_color(ham_hi_s1, ham_lo_s1);
		hold_base = item_s1.line_start ? c0_s1 : hold_q;
		hold_next = hold_base;
		mod_val   = {item_s1.mod_hi, 2'b00};
		if (item_s1.bkg_load) begin
			hold_next = c0_s1;
		end else if (item_s1.ham_update) begin
			case (item_s1.ctrl)
				HAM_LOAD: hold_next = ham_col;
				HAM_BLUE: begin
					mod_val   = {item_s1.mod_hi, item_s1.keep_low ? hold_base[1:0] : 2'b00};
					hold_next = {hold_base[23:8], mod_val};
				end
				HAM_RED: begin
					mod_val   = {item_s1.mod_hi, item_s1.keep_low ? hold_base[17:16] : 2'b00};
					hold_next = {mod_val, hold_base[15:0]};
				end
				HAM_GREEN: begin
					mod_val   = {item_s1.mod_hi, item_s1.keep_low ? hold_base[9:8] : 2'b00};
					hold_next = {hold_base[23:16], mod_val, hold_base[7:0]};
				end
				default: hold_next = hold_base;
			endcase
		end
		case (item_s1.sel)
			SEL_BACKGROUND: rgb = c0_s1;
			SEL_BLANK:      rgb = 24'd0;
			SEL_DEBUG:      rgb = DEBUG_RGB;
			SEL_PALETTE:    rgb = pal_col;
			SEL_HAM:        rgb = hold_next;
			default:        rgb = 24'd0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16]};

	a_hold_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> (hold_q == $past(hold_q)))
		else $error("hold register changed without a pixel leaving stage 1");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("pixel left stage 1 but output register is empty");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for ham_palette_colorizer: directed and random items checked against a colour predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hpc_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 40;

	typedef struct {
		logic        op;
		logic        line_start;
		border_t     border;
		logic        sprite_present;
		logic        sprite_visible;
		logic [7:0]  plane_data;
		logic [7:0]  plane_index;
		logic [7:0]  mix_index;
		logic [7:0]  reg_number;
		logic [11:0] reg_value;
		logic        low_nibbles;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// line_start, border_code[1:0], sprite_present, sprite_visible, plane_data[7:0],
	// plane_index[7:0], mix_index[7:0], reg_number[7:0], reg_value[11:0], low_nibbles
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	// op
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// red[7:0], green[7:0], blue[7:0]
	logic [M_TDATA_W-1:0]  m_axis_tdata;

	// predictor state
	logic [23:0] palette_mirror [0:PALETTE_ENTRIES_DEF-1];
	logic [23:0] hold_mirror;
	pix_mode_t   mode_mirror;
	logic        halfbright_mirror;
	logic        aga_mirror;
	logic        border_spr_mirror;

	rgb_t        colour_due [$];
	rgb_t        oldest_colour;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	bit          burst_mode = 1'b0;

	ham_palette_colorizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// random pause length, now and then a long pause up to longest
	function automatic int unsigned random_pause(input int unsigned longest);
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(4, longest);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!burst_mode && $urandom_range(0, 99) < 12) begin
			stall_left = random_pause(30) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (colour_due.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %06h", m_axis_tdata));
			end else begin
				oldest_colour = colour_due.pop_front();
				if (m_axis_tdata[7:0] !== oldest_colour.red)
					report_mismatch($sformatf("red %02h, predicted %02h",
						m_axis_tdata[7:0], oldest_colour.red));
				if (m_axis_tdata[15:8] !== oldest_colour.green)
					report_mismatch($sformatf("green %02h, predicted %02h",
						m_axis_tdata[15:8], oldest_colour.green));
				if (m_axis_tdata[23:16] !== oldest_colour.blue)
					report_mismatch($sformatf("blue %02h, predicted %02h",
						m_axis_tdata[23:16], oldest_colour.blue));
			end
		end
	end

	// entries 32 to 63 read as halved copies of 0 to 31 when halfbright is on
	function automatic logic [23:0] palette_colour(input logic [7:0] idx);
		if (halfbright_mirror && idx >= 8'd32 && idx < 8'd64)
			return (palette_mirror[idx - 8'd32] >> 1) & HALF_MASK;
		return palette_mirror[idx];
	endfunction

	function automatic void store_colour_write(input stream_item_t it);
		logic [23:0] c;
		logic [11:0] v;
		c = palette_mirror[it.reg_number];
		v = it.reg_value;
		if (aga_mirror && it.low_nibbles)
			c = {c[23:20], v[11:8], c[15:12], v[7:4], c[7:4], v[3:0]};
		else if (aga_mirror)
			c = {v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
		else
			c = {v[11:8], 4'h0, v[7:4], 4'h0, v[3:0], 4'h0};
		palette_mirror[it.reg_number] = c;
	endfunction

	function automatic void modify_hold(input ham_ctrl_t ctrl, input logic [7:0] idx,
			input bit ham8);
		int unsigned sh;
		if (ctrl == HAM_LOAD) begin
			hold_mirror = palette_mirror[ham8 ? {2'b00, idx[7:2]} : idx];
		end else begin
			case (ctrl)
				HAM_BLUE: sh = 0;
				HAM_RED:  sh = 16;
				default:  sh = 8;
			endcase
			// HAM8 keeps the two low bits of the old component
			if (ham8)
				hold_mirror[sh +: 8] = {idx[7:2], hold_mirror[sh +: 2]};
			else
				hold_mirror[sh +: 8] = {idx[3:0], 4'h0};
		end
	endfunction

	// Advance the predictor by one item; returns 1 when the item yields a pixel.
	function automatic bit predict_colour(input stream_item_t it, output rgb_t rgb);
		border_t   bc;
		bit        ham;
		bit        ham8;
		ham_ctrl_t ctrl;
		rgb = '0;
		if (it.op) begin
			store_colour_write(it);
			return 1'b0;
		end
		ham8 = (mode_mirror == MODE_HAM8);
		ham = ham8 || (mode_mirror == MODE_HAM6);
		if (it.line_start)
			hold_mirror = palette_mirror[0];
		bc = (border_spr_mirror && it.sprite_present) ? BORDER_CLEAR : it.border;
		case (bc)
			BORDER_BACKGROUND: begin
				rgb = palette_colour(8'd0);
				if (ham)
					hold_mirror = palette_mirror[0];
			end
			BORDER_BLANK: rgb = '0;
			BORDER_RED: rgb = DEBUG_RGB;
			default: begin
				if (ham) begin
					ctrl = ham_ctrl_t'(ham8 ? it.plane_data[1:0] : it.plane_data[5:4]);
					modify_hold(ctrl, it.plane_index, ham8);
					rgb = it.sprite_visible ? palette_colour(it.mix_index) : hold_mirror;
				end else begin
					rgb = palette_colour(it.mix_index);
				end
			end
		endcase
		return 1'b1;
	endfunction

	task automatic send_item(input stream_item_t it);
		int unsigned gap;
		rgb_t rgb;
		gap = (burst_mode || $urandom_range(0, 99) < 60) ? 0 : random_pause(20);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {{(S_TDATA_W - 50){1'b0}}, it.low_nibbles, it.reg_value,
			it.reg_number, it.mix_index, it.plane_index, it.plane_data,
			it.sprite_visible, it.sprite_present, it.border, it.line_start};
		do @(posedge clk); while (!s_axis_tready);
		if (predict_colour(it, rgb))
			colour_due.push_back(rgb);
	endtask

	// Drop valid, let every pixel come back and give colour writes time to land.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (colour_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input cfg_reg_t idx, input logic [1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_PIXEL_MODE: mode_mirror = pix_mode_t'(val);
			CFG_HALFBRIGHT: halfbright_mirror = val[0];
			CFG_AGA_WRITES: aga_mirror = val[0];
			default:        border_spr_mirror = val[0];
		endcase
	endtask

	task automatic set_config(input pix_mode_t mode, input logic hb, input logic aga,
			input logic bspr);
		wait_idle();
		write_config(CFG_PIXEL_MODE, mode);
		write_config(CFG_HALFBRIGHT, {1'b0, hb});
		write_config(CFG_AGA_WRITES, {1'b0, aga});
		write_config(CFG_BORDER_SPR, {1'b0, bspr});
	endtask

	function automatic logic [7:0] low_biased_index();
		if ($urandom_range(0, 99) < 60)
			return 8'($urandom_range(0, 63));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic stream_item_t random_item();
		stream_item_t it;
		it.op = 1'($urandom_range(0, 1));
		it.line_start = 1'($urandom_range(0, 1));
		it.border = border_t'(2'($urandom_range(0, 3)));
		it.sprite_present = 1'($urandom_range(0, 1));
		it.sprite_visible = 1'($urandom_range(0, 1));
		it.plane_data = 8'($urandom_range(0, 255));
		it.plane_index = 8'($urandom_range(0, 255));
		it.mix_index = 8'($urandom_range(0, 255));
		it.reg_number = 8'($urandom_range(0, 255));
		it.reg_value = 12'($urandom_range(0, 4095));
		it.low_nibbles = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// unused fields stay random: the block must ignore them
	function automatic stream_item_t write_item(input logic [7:0] regno,
			input logic [11:0] val, input logic loct);
		stream_item_t it;
		it = random_item();
		it.op = 1'b1;
		it.reg_number = regno;
		it.reg_value = val;
		it.low_nibbles = loct;
		return it;
	endfunction

	function automatic stream_item_t pixel_item(input logic ls, input border_t bc,
			input logic spr_p, input logic spr_v, input logic [7:0] pdata,
			input logic [7:0] pidx, input logic [7:0] midx);
		stream_item_t it;
		it = random_item();
		it.op = 1'b0;
		it.line_start = ls;
		it.border = bc;
		it.sprite_present = spr_p;
		it.sprite_visible = spr_v;
		it.plane_data = pdata;
		it.plane_index = pidx;
		it.mix_index = midx;
		return it;
	endfunction

	task automatic test_after_reset();
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd0));
		send_item(pixel_item(1'b1, BORDER_CLEAR, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'd255));
	endtask

	task automatic test_ocs_writes();
		// low nibble flag has no effect outside AGA rules
		send_item(write_item(8'd0, 12'hFFF, 1'b1));
		send_item(write_item(8'd255, 12'h123, 1'b0));
		send_item(write_item(8'd5, 12'hA5C, 1'b0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd255));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd0));
	endtask

	task automatic test_aga_writes();
		set_config(MODE_NORMAL, 1'b0, 1'b1, 1'b0);
		send_item(write_item(8'd5, 12'h3C9, 1'b1));
		send_item(write_item(8'd1, 12'h8F0, 1'b0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd5));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd1));
	endtask

	task automatic test_borders();
		set_config(MODE_NORMAL, 1'b0, 1'b1, 1'b1);
		send_item(pixel_item(1'b0, BORDER_BACKGROUND, 1'b0, 1'b0, 8'h00, 8'h00, 8'd5));
		send_item(pixel_item(1'b0, BORDER_BLANK, 1'b0, 1'b0, 8'h00, 8'h00, 8'd5));
		send_item(pixel_item(1'b0, BORDER_RED, 1'b0, 1'b0, 8'h00, 8'h00, 8'd5));
		// sprite over the border wins
		send_item(pixel_item(1'b0, BORDER_RED, 1'b1, 1'b0, 8'h00, 8'h00, 8'd1));
	endtask

	task automatic test_halfbright();
		set_config(MODE_NORMAL, 1'b1, 1'b1, 1'b0);
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd31));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd32));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd37));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd63));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'h00, 8'd64));
	endtask

	task automatic test_ham6();
		set_config(MODE_HAM6, 1'b1, 1'b1, 1'b0);
		send_item(pixel_item(1'b1, BORDER_CLEAR, 1'b0, 1'b0, 8'h00, 8'd5, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h10, 8'hFF, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'hE0, 8'hA3, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b1, 8'h30, 8'h0F, 8'd37));
		send_item(pixel_item(1'b0, BORDER_BACKGROUND, 1'b0, 1'b0, 8'h10, 8'h00, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h10, 8'h07, 8'd0));
	endtask

	task automatic test_ham8();
		set_config(MODE_HAM8, 1'b0, 1'b1, 1'b0);
		send_item(pixel_item(1'b1, BORDER_CLEAR, 1'b0, 1'b0, 8'hFC, 8'h17, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h01, 8'hFC, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h02, 8'h00, 8'd0));
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b0, 8'h03, 8'hFF, 8'd0));
		send_item(pixel_item(1'b1, BORDER_CLEAR, 1'b0, 1'b0, 8'h03, 8'h80, 8'd0));
	endtask

	task automatic test_spare_mode();
		// the spare mode code decodes as the plain palette
		set_config(MODE_UNUSED, 1'b0, 1'b0, 1'b0);
		send_item(pixel_item(1'b0, BORDER_CLEAR, 1'b0, 1'b1, 8'h00, 8'h00, 8'd5));
	endtask

	task automatic test_random_lines();
		int unsigned sent;
		int unsigned line_len;
		int unsigned pick;
		stream_item_t it;
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				set_config(MODE_NORMAL, 1'b0, 1'b0, 1'b0);
			else if (phase == 1)
				set_config(MODE_HAM8, 1'b1, 1'b1, 1'b1);
			else
				set_config(pix_mode_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			burst_mode = (phase % 4 == 3);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				line_len = $urandom_range(1, 24);
				for (int unsigned px = 0; px < line_len && sent < ITEMS_PER_PHASE; px++) begin
					pick = $urandom_range(0, 99);
					if (pick < 12) begin
						it = write_item(low_biased_index(), 12'($urandom_range(0, 4095)),
							1'($urandom_range(0, 1)));
					end else if (pick < 17) begin
						it = random_item();
					end else begin
						it = pixel_item(px == 0, BORDER_CLEAR, $urandom_range(0, 99) < 20,
							$urandom_range(0, 99) < 25, 8'($urandom_range(0, 255)),
							low_biased_index(), low_biased_index());
						if ($urandom_range(0, 99) < 20)
							it.border = border_t'(2'($urandom_range(1, 3)));
					end
					send_item(it);
					sent++;
				end
			end
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < PALETTE_ENTRIES_DEF; i++)
			palette_mirror[i] = '0;
		hold_mirror = '0;
		mode_mirror = MODE_NORMAL;
		halfbright_mirror = 1'b0;
		aga_mirror = 1'b0;
		border_spr_mirror = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_ocs_writes();
		test_aga_writes();
		test_borders();
		test_halfbright();
		test_ham6();
		test_ham8();
		test_spare_mode();
		test_random_lines();

		wait_idle();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
